/* rtl/vst_pkg.sv */
// Shared widths, stage counts and arithmetic step functions for the vector soft threshold.
package vst_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned SUM_W       = 33;
    localparam int unsigned SQ_W        = 66;
    localparam int unsigned ROOT_W      = 33;
    localparam int unsigned SQRT_REM_W  = 36;
    localparam int unsigned SQRT_STAGES = 33;
    localparam int unsigned DIV_STAGES  = 33;
    localparam int unsigned LANES       = 3;
    localparam logic [DATA_W-1:0] INV_LAMBDA_RST = 32'h0001_0000;

    typedef struct packed {
        logic [SQRT_REM_W-1:0] rem;
        logic [ROOT_W-1:0]     root;
    } sqrt_step_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic              qbit;
    } div_step_t;

    function automatic sqrt_step_t sqrt_step(
        input logic [SQRT_REM_W-1:0] rem,
        input logic [ROOT_W-1:0]     root,
        input logic [1:0]            pair
    );
        logic [SQRT_REM_W-1:0] rem_t;
        logic [SQRT_REM_W-1:0] trial;
        sqrt_step_t            res;
        rem_t = {rem[SQRT_REM_W-3:0], pair};
        trial = {1'b0, root, 2'b01};
        if (rem_t >= trial)
        begin
            res.rem  = rem_t - trial;
            res.root = {root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = rem_t;
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    function automatic div_step_t div_step(
        input logic [ROOT_W-1:0] rem,
        input logic              dbit,
        input logic [ROOT_W-1:0] divisor
    );
        logic [ROOT_W:0] rem_t;
        logic [ROOT_W:0] diff;
        div_step_t       res;
        rem_t = {rem, dbit};
        diff  = rem_t - {1'b0, divisor};
        if (rem_t >= {1'b0, divisor})
        begin
            res.rem  = diff[ROOT_W-1:0];
            res.qbit = 1'b1;
        end
        else
        begin
            res.rem  = rem_t[ROOT_W-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

/* rtl/vst_if.sv */
// Item channel interfaces for the vector soft threshold.
interface vst_in_if
    import vst_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] grad_x;
    logic [DATA_W-1:0] grad_y;
    logic [DATA_W-1:0] grad_z;
    logic [DATA_W-1:0] breg_x;
    logic [DATA_W-1:0] breg_y;
    logic [DATA_W-1:0] breg_z;

    modport source (output valid, grad_x, grad_y, grad_z, breg_x, breg_y, breg_z,
                    input ready);
    modport sink   (input valid, grad_x, grad_y, grad_z, breg_x, breg_y, breg_z,
                    output ready);
endinterface

interface vst_out_if
    import vst_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] shrunk_x;
    logic [DATA_W-1:0] shrunk_y;
    logic [DATA_W-1:0] shrunk_z;

    modport source (output valid, shrunk_x, shrunk_y, shrunk_z, input ready);
    modport sink   (input valid, shrunk_x, shrunk_y, shrunk_z, output ready);
endinterface

/* rtl/vst_sqrt_pipe.sv */
// Pipelined floor square root, one radicand bit pair per stage.
module vst_sqrt_pipe
    import vst_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   rad,
    output logic [ROOT_W-1:0] root
);

    logic [SQRT_REM_W-1:0] rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0]     root_reg [SQRT_STAGES];
    logic [SQ_W-1:0]       rad_reg  [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        localparam int unsigned P = SQRT_STAGES - 1 - k;
        logic [SQRT_REM_W-1:0] rem_prev;
        logic [ROOT_W-1:0]     root_prev;
        logic [SQ_W-1:0]       rad_prev;
        sqrt_step_t            step_next;

        if (k == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
        end

        assign step_next = sqrt_step(rem_prev, root_prev, rad_prev[2*P+1 -: 2]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= step_next.rem;
                root_reg[k] <= step_next.root;
                rad_reg[k]  <= rad_prev;
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

/* rtl/vst_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage.
module vst_div_pipe
    import vst_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   dividend,
    input  logic [ROOT_W-1:0] divisor,
    output logic [ROOT_W-1:0] quot
);

    logic [ROOT_W-1:0] rem_reg  [DIV_STAGES];
    logic [ROOT_W-1:0] low_reg  [DIV_STAGES];
    logic [ROOT_W-1:0] dvs_reg  [DIV_STAGES];
    logic [ROOT_W-1:0] quot_reg [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        localparam int unsigned B = DIV_STAGES - 1 - j;
        logic [ROOT_W-1:0] rem_prev;
        logic [ROOT_W-1:0] low_prev;
        logic [ROOT_W-1:0] dvs_prev;
        logic [ROOT_W-1:0] quot_prev;
        div_step_t         step_next;

        if (j == 0)
        begin : g_first
            assign rem_prev  = dividend[SQ_W-1:ROOT_W];
            assign low_prev  = dividend[ROOT_W-1:0];
            assign dvs_prev  = divisor;
            assign quot_prev = '0;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[j-1];
            assign low_prev  = low_reg[j-1];
            assign dvs_prev  = dvs_reg[j-1];
            assign quot_prev = quot_reg[j-1];
        end

        assign step_next = div_step(rem_prev, low_prev[B], dvs_prev);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= step_next.rem;
                low_reg[j]  <= low_prev;
                dvs_reg[j]  <= dvs_prev;
                quot_reg[j] <= {quot_prev[ROOT_W-2:0], step_next.qbit};
            end
        end
    end

    assign quot = quot_reg[DIV_STAGES-1];

endmodule

/* rtl/vector_soft_threshold_unit.sv */
// Top level of the isotropic vector soft threshold pipeline.
// Stages from accepted item to valid result: add, square, sum,
// 33 root stages, threshold, product, 33 divider stages, output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits and loads inv_lambda with 1.0 (0x00010000).
module vector_soft_threshold_unit
    import vst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              inv_lambda_we,
    input  logic [DATA_W-1:0] inv_lambda_wdata,
    vst_in_if.sink            voxel,
    vst_out_if.source         shrunk
);

    logic                 en;
    logic [DATA_W-1:0]    inv_lambda_reg;
    logic [DATA_W-1:0]    in_a [LANES];
    logic [DATA_W-1:0]    in_b [LANES];

    logic                 v_a_reg;
    logic [LANES-1:0]     sign_a_reg;
    logic [SUM_W-1:0]     mag_a_reg [LANES];
    logic                 v_b_reg;
    logic [LANES-1:0]     sign_b_reg;
    logic [SUM_W-1:0]     mag_b_reg [LANES];
    logic [SQ_W-1:0]      sq_b_reg  [LANES];
    logic                 v_c_reg;
    logic [LANES-1:0]     sign_c_reg;
    logic [SUM_W-1:0]     mag_c_reg [LANES];
    logic [SQ_W-1:0]      sum_c_reg;

    logic [SQRT_STAGES-1:0] v_s_reg;
    logic [LANES-1:0]       sign_s_reg [SQRT_STAGES];
    logic [SUM_W-1:0]       mag_s_reg  [SQRT_STAGES][LANES];
    logic [ROOT_W-1:0]      root;

    logic                 v_e_reg;
    logic [LANES-1:0]     sign_e_reg;
    logic [SUM_W-1:0]     mag_e_reg [LANES];
    logic [ROOT_W-1:0]    root_e_reg;
    logic [ROOT_W-1:0]    shrink_e_reg;
    logic                 zero_e_reg;
    logic [ROOT_W-1:0]    shrink_next;

    logic                 v_f_reg;
    logic [LANES-1:0]     sign_f_reg;
    logic [ROOT_W-1:0]    root_f_reg;
    logic                 zero_f_reg;
    logic [SQ_W-1:0]      prod_f_reg [LANES];

    logic [DIV_STAGES-1:0] v_d_reg;
    logic [LANES-1:0]      sign_d_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] zero_d_reg;
    logic [ROOT_W-1:0]     quot [LANES];

    logic                 out_valid_reg;
    logic [DATA_W-1:0]    res_reg  [LANES];
    logic [DATA_W-1:0]    res_next [LANES];

    assign en          = !out_valid_reg || shrunk.ready;
    assign voxel.ready = en;

    assign in_a[0] = voxel.grad_x;
    assign in_a[1] = voxel.grad_y;
    assign in_a[2] = voxel.grad_z;
    assign in_b[0] = voxel.breg_x;
    assign in_b[1] = voxel.breg_y;
    assign in_b[2] = voxel.breg_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_lambda_reg <= INV_LAMBDA_RST;
        end
        else if (inv_lambda_we)
        begin
            inv_lambda_reg <= inv_lambda_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg       <= 1'b0;
            v_b_reg       <= 1'b0;
            v_c_reg       <= 1'b0;
            v_s_reg       <= '0;
            v_e_reg       <= 1'b0;
            v_f_reg       <= 1'b0;
            v_d_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_a_reg       <= voxel.valid;
            v_b_reg       <= v_a_reg;
            v_c_reg       <= v_b_reg;
            v_s_reg       <= {v_s_reg[SQRT_STAGES-2:0], v_c_reg};
            v_e_reg       <= v_s_reg[SQRT_STAGES-1];
            v_f_reg       <= v_e_reg;
            v_d_reg       <= {v_d_reg[DIV_STAGES-2:0], v_f_reg};
            out_valid_reg <= v_d_reg[DIV_STAGES-1];
        end
    end

    // add, square, sum; carry magnitudes and form the per-lane product
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic signed [SUM_W-1:0] s_next;
        assign s_next = SUM_W'($signed(in_a[i])) + SUM_W'($signed(in_b[i]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sign_a_reg[i] <= s_next[SUM_W-1];
                mag_a_reg[i]  <= s_next[SUM_W-1] ? SUM_W'(-s_next) : SUM_W'(s_next);
                sq_b_reg[i]   <= SQ_W'(mag_a_reg[i]) * SQ_W'(mag_a_reg[i]);
                mag_b_reg[i]  <= mag_a_reg[i];
                mag_c_reg[i]  <= mag_b_reg[i];
                mag_e_reg[i]  <= mag_s_reg[SQRT_STAGES-1][i];
                prod_f_reg[i] <= SQ_W'(mag_e_reg[i]) * SQ_W'(shrink_e_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_b_reg <= sign_a_reg;
            sign_c_reg <= sign_b_reg;
            sum_c_reg  <= sq_b_reg[0] + sq_b_reg[1] + sq_b_reg[2];
        end
    end

    vst_sqrt_pipe u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (sum_c_reg),
        .root (root)
    );

    // carry signs and magnitudes alongside the root
    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (k == 0)
                begin
                    sign_s_reg[k] <= sign_c_reg;
                    mag_s_reg[k]  <= mag_c_reg;
                end
                else
                begin
                    sign_s_reg[k] <= sign_s_reg[k-1];
                    mag_s_reg[k]  <= mag_s_reg[k-1];
                end
            end
        end
    end

    assign shrink_next = (root > ROOT_W'(inv_lambda_reg))
                       ? root - ROOT_W'(inv_lambda_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_e_reg   <= sign_s_reg[SQRT_STAGES-1];
            root_e_reg   <= root;
            shrink_e_reg <= shrink_next;
            zero_e_reg   <= (root == '0) || (shrink_next == '0);
            sign_f_reg   <= sign_e_reg;
            root_f_reg   <= root_e_reg;
            zero_f_reg   <= zero_e_reg;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_div
        vst_div_pipe u_div (
            .clk      (clk),
            .en       (en),
            .dividend (prod_f_reg[i]),
            .divisor  (root_f_reg),
            .quot     (quot[i])
        );
    end

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_dside
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (j == 0)
                begin
                    sign_d_reg[j] <= sign_f_reg;
                    zero_d_reg[j] <= zero_f_reg;
                end
                else
                begin
                    sign_d_reg[j] <= sign_d_reg[j-1];
                    zero_d_reg[j] <= zero_d_reg[j-1];
                end
            end
        end
    end

    // apply signs, force zero results and saturate to signed 32 bits
    for (genvar i = 0; i < LANES; i++)
    begin : g_sat
        logic [ROOT_W-1:0] neg_q;
        logic [ROOT_W-1:0] mag_lim;
        assign mag_lim = (quot[i] > ROOT_W'(33'h0_8000_0000)) ? ROOT_W'(33'h0_8000_0000)
                                                              : quot[i];
        assign neg_q   = -mag_lim;

        always_comb
        begin
            if (zero_d_reg[DIV_STAGES-1])
            begin
                res_next[i] = '0;
            end
            else if (sign_d_reg[DIV_STAGES-1][i])
            begin
                res_next[i] = neg_q[DATA_W-1:0];
            end
            else if (quot[i] > ROOT_W'(33'h0_7FFF_FFFF))
            begin
                res_next[i] = 32'h7FFF_FFFF;
            end
            else
            begin
                res_next[i] = quot[i][DATA_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    assign shrunk.valid    = out_valid_reg;
    assign shrunk.shrunk_x = res_reg[0];
    assign shrunk.shrunk_y = res_reg[1];
    assign shrunk.shrunk_z = res_reg[2];

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (v_d_reg[DIV_STAGES-1] && !zero_d_reg[DIV_STAGES-1])
        |-> ((!quot[0][ROOT_W-1] || quot[0][DATA_W-1:0] == '0)
          && (!quot[1][ROOT_W-1] || quot[1][DATA_W-1:0] == '0)
          && (!quot[2][ROOT_W-1] || quot[2][DATA_W-1:0] == '0)))
        else $error("quotient exceeds magnitude bound");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v_f_reg) && $stable(v_c_reg) && $stable(v_d_reg)))
        else $error("pipeline advanced during stall");

endmodule
